[rtl/core/i2cm_pkg.sv]
// Shared types and codes for the I2C master bit engine.
// Used by the sequencer, the output buffer and the top level; no dependencies.
package i2cm_pkg;

  // Command codes carried in the operation field.
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_ACK_WAIT = 3'd4,
    OP_READ     = 3'd5
  } op_t;

  // Configuration register indexes.
  localparam logic CFG_UNIT_TICKS     = 1'b0;
  localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

  // Bus phase sequence, one-hot.
  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_START_A  = 19'h00002,
    ST_START_B  = 19'h00004,
    ST_STOP_A   = 19'h00008,
    ST_STOP_B   = 19'h00010,
    ST_STOP_C   = 19'h00020,
    ST_ACK_A    = 19'h00040,
    ST_ACK_B    = 19'h00080,
    ST_ACK_POLL = 19'h00100,
    ST_WR_SET   = 19'h00200,
    ST_WR_HI    = 19'h00400,
    ST_WR_LO    = 19'h00800,
    ST_RD_LO    = 19'h01000,
    ST_RD_HI    = 19'h02000,
    ST_RA_A     = 19'h04000,
    ST_RA_B     = 19'h08000,
    ST_TO_A     = 19'h10000,
    ST_TO_B     = 19'h20000,
    ST_TO_C     = 19'h40000
  } step_t;

  // Configuration values handed to the sequencer.
  typedef struct packed {
    logic [7:0] unit_ticks;
    logic [7:0] ack_poll_limit;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;
  } res_t;

endpackage

[rtl/core/i2cm_seq.sv]
// Phase sequencer of the I2C master: state registers and the one-tick update.
// Depends on i2cm_pkg for the step, config and result types.
module i2cm_seq import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [2:0] operation,
  input  logic [7:0] write_data,
  input  logic       give_ack,
  input  logic       sda_line,
  input  cfg_t       cfg,
  output res_t       res_nxt
);

  typedef struct packed {
    step_t      step;
    logic [3:0] bit_cnt;
    logic [9:0] delay_cnt;
    logic [8:0] poll_cnt;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic       sda_en;
    logic       ack_choice;
    logic [7:0] rx_byte;
    logic       ack_err;
    logic       done;
  } seq_state_t;

  seq_state_t state_r;
  seq_state_t state_nxt;

  function automatic seq_state_t finish_st(seq_state_t s);
    seq_state_t r;
    r           = s;
    r.step      = ST_IDLE;
    r.delay_cnt = '0;
    r.done      = 1'b1;
    return r;
  endfunction

  // Enter a phase: set its levels and load its hold time (1, 2 or 4 units).
  function automatic seq_state_t enter_st(seq_state_t s, step_t nxt, logic sda_in,
                                          logic [7:0] unit);
    seq_state_t r;
    logic [9:0] u10;
    r   = s;
    u10 = (unit == 8'd0) ? 10'd1 : {2'b00, unit};
    r.step = nxt;
    unique case (nxt)
      ST_START_A: begin
        r.sda_en = 1'b1; r.sda = 1'b1; r.scl = 1'b1; r.delay_cnt = u10 << 2;
      end
      ST_START_B: begin
        r.sda = 1'b0; r.delay_cnt = u10 << 2;
      end
      ST_STOP_A, ST_TO_A: begin
        r.sda_en = 1'b1; r.scl = 1'b0; r.sda = 1'b0; r.delay_cnt = u10 << 2;
      end
      ST_STOP_B, ST_TO_B: begin
        r.scl = 1'b1; r.delay_cnt = u10;
      end
      ST_STOP_C, ST_TO_C: begin
        r.sda = 1'b1; r.delay_cnt = u10 << 2;
      end
      ST_ACK_A: begin
        r.sda_en = 1'b0; r.sda = 1'b1; r.delay_cnt = u10;
      end
      ST_ACK_B: begin
        r.scl = 1'b1; r.delay_cnt = u10;
      end
      ST_WR_SET: begin
        r.sda_en = 1'b1; r.scl = 1'b0; r.sda = s.shift[7];
        r.shift = {s.shift[6:0], 1'b0};
        r.delay_cnt = u10 << 1;
      end
      ST_WR_HI: begin
        r.scl = 1'b1; r.delay_cnt = u10 << 1;
      end
      ST_WR_LO: begin
        r.scl = 1'b0; r.delay_cnt = u10 << 1;
      end
      ST_RD_LO: begin
        r.sda_en = 1'b0; r.scl = 1'b0; r.delay_cnt = u10 << 1;
      end
      ST_RD_HI: begin
        r.scl = 1'b1; r.shift = {s.shift[6:0], sda_in}; r.delay_cnt = u10;
      end
      ST_RA_A: begin
        r.scl = 1'b0; r.sda_en = 1'b1; r.sda = ~s.ack_choice; r.delay_cnt = u10 << 1;
      end
      ST_RA_B: begin
        r.scl = 1'b1; r.delay_cnt = u10 << 1;
      end
      default: begin
        r.delay_cnt = '0;
      end
    endcase
    return r;
  endfunction

  // One acknowledge poll: SDA low ends the wait, too many high polls start a stop.
  function automatic seq_state_t poll_st(seq_state_t s, logic sda_in, cfg_t c);
    seq_state_t r;
    r = s;
    if (!sda_in) begin
      r.scl     = 1'b0;
      r.ack_err = 1'b0;
      r         = finish_st(r);
    end else begin
      if (r.poll_cnt != 9'h1FF) begin
        r.poll_cnt = r.poll_cnt + 9'd1;
      end
      if (r.poll_cnt > {1'b0, c.ack_poll_limit}) begin
        r = enter_st(r, ST_TO_A, sda_in, c.unit_ticks);
      end
    end
    return r;
  endfunction

  function automatic seq_state_t advance_st(seq_state_t s, logic sda_in, cfg_t c);
    seq_state_t r;
    r = s;
    unique case (s.step)
      ST_START_A: r = enter_st(r, ST_START_B, sda_in, c.unit_ticks);
      ST_START_B: begin
        r.scl = 1'b0;
        r     = finish_st(r);
      end
      ST_STOP_A:  r = enter_st(r, ST_STOP_B, sda_in, c.unit_ticks);
      ST_STOP_B:  r = enter_st(r, ST_STOP_C, sda_in, c.unit_ticks);
      ST_ACK_A:   r = enter_st(r, ST_ACK_B, sda_in, c.unit_ticks);
      ST_ACK_B: begin
        r = enter_st(r, ST_ACK_POLL, sda_in, c.unit_ticks);
        r = poll_st(r, sda_in, c);
      end
      ST_WR_SET:  r = enter_st(r, ST_WR_HI, sda_in, c.unit_ticks);
      ST_WR_HI:   r = enter_st(r, ST_WR_LO, sda_in, c.unit_ticks);
      ST_WR_LO: begin
        r.bit_cnt = s.bit_cnt + 4'd1;
        if (r.bit_cnt >= 4'd8) begin
          r = finish_st(r);
        end else begin
          r = enter_st(r, ST_WR_SET, sda_in, c.unit_ticks);
        end
      end
      ST_RD_LO:   r = enter_st(r, ST_RD_HI, sda_in, c.unit_ticks);
      ST_RD_HI: begin
        r.bit_cnt = s.bit_cnt + 4'd1;
        if (r.bit_cnt >= 4'd8) begin
          r = enter_st(r, ST_RA_A, sda_in, c.unit_ticks);
        end else begin
          r = enter_st(r, ST_RD_LO, sda_in, c.unit_ticks);
        end
      end
      ST_RA_A:    r = enter_st(r, ST_RA_B, sda_in, c.unit_ticks);
      ST_RA_B: begin
        r.scl     = 1'b0;
        r.rx_byte = s.shift;
        r         = finish_st(r);
      end
      ST_TO_A:    r = enter_st(r, ST_TO_B, sda_in, c.unit_ticks);
      ST_TO_B:    r = enter_st(r, ST_TO_C, sda_in, c.unit_ticks);
      ST_TO_C: begin
        r.scl     = 1'b0;
        r.ack_err = 1'b1;
        r         = finish_st(r);
      end
      default:    r = finish_st(r);
    endcase
    return r;
  endfunction

  always_comb begin
    state_nxt      = state_r;
    state_nxt.done = 1'b0;
    if (state_r.step == ST_IDLE) begin
      case (operation)
        OP_START: state_nxt = enter_st(state_nxt, ST_START_A, sda_line, cfg.unit_ticks);
        OP_STOP:  state_nxt = enter_st(state_nxt, ST_STOP_A, sda_line, cfg.unit_ticks);
        OP_WRITE: begin
          state_nxt.shift   = write_data;
          state_nxt.bit_cnt = '0;
          state_nxt = enter_st(state_nxt, ST_WR_SET, sda_line, cfg.unit_ticks);
        end
        OP_ACK_WAIT: begin
          state_nxt.poll_cnt = '0;
          state_nxt = enter_st(state_nxt, ST_ACK_A, sda_line, cfg.unit_ticks);
        end
        OP_READ: begin
          state_nxt.ack_choice = give_ack;
          state_nxt.bit_cnt    = '0;
          state_nxt.shift      = '0;
          state_nxt = enter_st(state_nxt, ST_RD_LO, sda_line, cfg.unit_ticks);
        end
        default: ;
      endcase
    end else if (state_r.step == ST_ACK_POLL) begin
      state_nxt = poll_st(state_nxt, sda_line, cfg);
    end else begin
      if (state_nxt.delay_cnt != 10'd0) begin
        state_nxt.delay_cnt = state_nxt.delay_cnt - 10'd1;
      end
      if (state_nxt.delay_cnt == 10'd0) begin
        state_nxt = advance_st(state_nxt, sda_line, cfg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.step       <= ST_IDLE;
      state_r.bit_cnt    <= '0;
      state_r.delay_cnt  <= '0;
      state_r.poll_cnt   <= '0;
      state_r.shift      <= '0;
      state_r.scl        <= 1'b1;
      state_r.sda        <= 1'b1;
      state_r.sda_en     <= 1'b1;
      state_r.ack_choice <= 1'b0;
      state_r.rx_byte    <= '0;
      state_r.ack_err    <= 1'b0;
      state_r.done       <= 1'b0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

  assign res_nxt.scl_out     = state_nxt.scl;
  assign res_nxt.sda_out     = state_nxt.sda;
  assign res_nxt.sda_drive   = state_nxt.sda_en;
  assign res_nxt.busy_res    = (state_nxt.step != ST_IDLE);
  assign res_nxt.done_res    = state_nxt.done;
  assign res_nxt.read_data   = state_nxt.rx_byte;
  assign res_nxt.ack_missing = state_nxt.ack_err;

endmodule

[rtl/core/i2cm_out_buf.sv]
// Two-entry output buffer (output register plus skid register) for result items.
// Depends on i2cm_pkg for the result type.
module i2cm_out_buf import i2cm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic can_push,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_data_r;
  res_t skid_data_r;
  logic pop;

  assign pop      = out_valid_r && out_ready;
  assign can_push = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: stream ports, configuration registers,
// sequencer and output buffer. Depends on i2cm_pkg, i2cm_seq and i2cm_out_buf.
//
// Each input transaction is one time tick of the bus sequencer and produces exactly
// one result transaction, which carries the SCL/SDA levels, the SDA drive enable,
// busy, done, the last byte read and the acknowledge error as they stand after that
// tick. The block takes one transaction per clock cycle while in_tready is high; the
// whole tick update is a single combinational pass from the sequencer state registers,
// and the result is registered into the output buffer when the input is accepted. An
// output register backed by a skid register lets one more input transaction in when
// the output stalls, after which in_tready drops until the output drains. A command
// (start, stop, write, acknowledge wait, read) is taken only on a tick that starts
// idle; while a sequence runs the operation field is ignored. Configuration writes
// (unit_ticks, ack_poll_limit) should be made only while the block is idle. There is
// no clearing pass after reset.
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // From bit 0: operation[2:0], write_data[10:3], give_ack[11], sda_line[12], zeros.
  input  logic [15:0] in_tdata,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // From bit 0: scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
  // read_data[12:5], ack_missing[13], zeros.
  output logic [15:0] out_tdata,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  cfg_t cfg_r;
  res_t res_nxt;
  res_t res_out;
  logic in_accept;

  assign in_accept = in_tvalid && in_tready;

  // Configuration registers; a unit length of zero acts as one inside the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_ticks     <= 8'd1;
      cfg_r.ack_poll_limit <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNIT_TICKS:     cfg_r.unit_ticks     <= cfg_wdata;
        CFG_ACK_POLL_LIMIT: cfg_r.ack_poll_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  i2cm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .operation  (in_tdata[2:0]),
    .write_data (in_tdata[10:3]),
    .give_ack   (in_tdata[11]),
    .sda_line   (in_tdata[12]),
    .cfg        (cfg_r),
    .res_nxt    (res_nxt)
  );

  i2cm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (res_nxt),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_out)
  );

  assign out_tdata = {2'b00, res_out.ack_missing, res_out.read_data, res_out.done_res,
                      res_out.busy_res, res_out.sda_drive, res_out.sda_out,
                      res_out.scl_out};

endmodule
